[rtl/mevk_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mevk_pkg
// Shared types, codes and the modifier decode table of the MIDI key mapper.
// ----------------------------------------------------------------------------
package mevk_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // Slot modes.
  localparam logic [3:0] MODE_OFF     = 4'd0;
  localparam logic [3:0] MODE_NOTE    = 4'd1;
  localparam logic [3:0] MODE_PC_UP   = 4'd2;
  localparam logic [3:0] MODE_PC_DN   = 4'd3;
  localparam logic [3:0] MODE_CC_MAX  = 4'd4;
  localparam logic [3:0] MODE_CC_MIN  = 4'd5;
  localparam logic [3:0] MODE_CC_HIGH = 4'd6;
  localparam logic [3:0] MODE_CC_LOW  = 4'd7;
  localparam logic [3:0] MODE_SL_UP   = 4'd8;
  localparam logic [3:0] MODE_SL_DN   = 4'd9;

  // Result actions.
  localparam logic [1:0] ACT_PRESS   = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_TAP     = 2'd2;
  localparam logic [1:0] ACT_PASS    = 2'd3;

  // MIDI message types (upper status nibble).
  localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
  localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;
  localparam logic [3:0] TYPE_CC       = 4'hb;
  localparam logic [3:0] TYPE_PROG     = 4'hc;

  // Controller value thresholds.
  localparam logic [6:0] CC_FULL   = 7'd127;
  localparam logic [6:0] CC_MID    = 7'd64;
  localparam logic [6:0] SL_HI_LIM = 7'd100;
  localparam logic [6:0] SL_LO_LIM = 7'd27;

  typedef struct packed {
    logic [3:0] mode;
    logic [6:0] number;
    logic [3:0] mod_code;
    logic [7:0] key;
  } slot_t;

  typedef struct packed {
    logic  held;
    slot_t slot;
  } cell_t;

  typedef struct packed {
    logic [3:0] msg_type;
    logic [6:0] d1;
    logic [6:0] d2;
    logic [6:0] last_prog;
    logic       listen_ok;
  } msg_t;

  typedef struct packed {
    logic       fire;
    logic [1:0] action;
    logic       held_nxt;
  } match_t;

  // Modifier code to mask: bit0 shift, bit1 control, bit2 alt, bit3 meta.
  function automatic logic [3:0] mod_decode(input logic [3:0] code);
    logic [3:0] m;
    case (code)
      4'd0:    m = 4'd0;
      4'd1:    m = 4'd1;
      4'd2:    m = 4'd2;
      4'd3:    m = 4'd4;
      4'd4:    m = 4'd8;
      4'd5:    m = 4'd3;
      4'd6:    m = 4'd5;
      4'd7:    m = 4'd9;
      4'd8:    m = 4'd6;
      4'd9:    m = 4'd10;
      4'd10:   m = 4'd12;
      4'd11:   m = 4'd7;
      4'd12:   m = 4'd11;
      4'd13:   m = 4'd13;
      4'd14:   m = 4'd14;
      default: m = 4'd15;
    endcase
    return m;
  endfunction

endpackage

[rtl/mevk_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mevk_cell
// One slot of the ring: holds a slot entry and its held mark.
// ----------------------------------------------------------------------------
module mevk_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  mevk_pkg::slot_t wr_slot,
  input  logic            shift_en,
  input  mevk_pkg::cell_t shift_in,
  output mevk_pkg::cell_t q
);
  import mevk_pkg::*;

  cell_t q_r, q_nxt;

  // A shift moves the whole entry; a slot write leaves the held mark alone.
  always_comb begin
    q_nxt = q_r;
    if (shift_en) begin
      q_nxt = shift_in;
    end else if (wr_en) begin
      q_nxt.slot = wr_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.held          <= 1'b0;
      q_r.slot.mode     <= MODE_OFF;
      q_r.slot.number   <= '0;
      q_r.slot.mod_code <= '0;
      q_r.slot.key      <= '0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

[rtl/mevk_match.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mevk_match
// Checks the slot at the head of the ring against the current message.
// ----------------------------------------------------------------------------
module mevk_match (
  input  mevk_pkg::cell_t  head,
  input  mevk_pkg::msg_t   msg,
  output mevk_pkg::match_t res
);
  import mevk_pkg::*;

  logic       hit;
  logic       want;
  logic       cc_tap;
  logic       slider;
  logic [3:0] m;

  assign m      = head.slot.mode;
  assign hit    = (msg.d1 == head.slot.number);
  assign slider = (m == MODE_SL_UP) || (m == MODE_SL_DN);
  assign cc_tap = ((m == MODE_CC_MAX)  && (msg.d2 == CC_FULL)) ||
                  ((m == MODE_CC_MIN)  && (msg.d2 == 7'd0))    ||
                  ((m == MODE_CC_HIGH) && (msg.d2 >  CC_MID))  ||
                  ((m == MODE_CC_LOW)  && (msg.d2 <  CC_MID));

  always_comb begin
    if (msg.d2 > SL_HI_LIM) begin
      want = (m == MODE_SL_UP);
    end else if (msg.d2 < SL_LO_LIM) begin
      want = (m == MODE_SL_DN);
    end else begin
      want = 1'b0;
    end
  end

  always_comb begin
    res.fire     = 1'b0;
    res.action   = ACT_TAP;
    res.held_nxt = head.held;
    if (msg.listen_ok) begin
      case (msg.msg_type)
        TYPE_NOTE_ON: begin
          res.fire   = hit && (m == MODE_NOTE);
          res.action = ACT_PRESS;
        end
        TYPE_NOTE_OFF: begin
          res.fire   = hit && (m == MODE_NOTE);
          res.action = ACT_RELEASE;
        end
        TYPE_PROG: begin
          // The 7-bit sums wrap the program number around.
          res.fire = ((m == MODE_PC_UP) && (msg.d1 == msg.last_prog + 7'd1)) ||
                     ((m == MODE_PC_DN) && (msg.d1 == msg.last_prog - 7'd1));
        end
        TYPE_CC: begin
          if (hit && cc_tap) begin
            res.fire = 1'b1;
          end else if (hit && slider) begin
            if (want && !head.held) begin
              res.fire     = 1'b1;
              res.action   = ACT_PRESS;
              res.held_nxt = 1'b1;
            end else if (!want && head.held) begin
              res.fire     = 1'b1;
              res.action   = ACT_RELEASE;
              res.held_nxt = 1'b0;
            end
          end
        end
        default: begin
          res.fire = 1'b0;
        end
      endcase
    end
  end

endmodule

[rtl/midi_event_to_key_action_mapper.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_event_to_key_action_mapper
// Maps three-byte MIDI messages to key press, release and tap actions.
// ----------------------------------------------------------------------------
// Usage. Items enter on the in_ stream. in_tuser selects a slot write (1) or
// a MIDI message (0). A slot write yields no transfer on the out_ stream. A
// message is checked against every slot in order; each matching slot yields
// one result, and a message that matches nothing is returned as a single
// pass-through result. out_tlast marks the final result of a message,
// out_tuser carries the action code.
// Operation: the slots sit in a ring of cells that rotates one position per
// cycle, while the output register is free, past a single match unit. After
// its transfer a message is scanned through all NUM_SLOTS slots and then
// closed in a final step that hands over the last result. No new message or
// slot write is accepted until the block is idle again. A key action is held
// back in the pending register until the next hit or the end of the scan
// shows whether it is the final one, and then moves to the output register.
// Stalls: a result waits in the output register; while it is not taken the
// ring stops rotating, so nothing is lost and the order is kept.
// Reset: all slots are off, every held mark and last program is zero and the
// listen channel is 0 (any channel). listen_channel sits at address 0 of the
// cfg_ port and must be written only while the block is idle; the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
module midi_event_to_key_action_mapper (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata, from bit 0: status_byte[7:0], first_data[15:8],
  // second_data[23:16], slot_index[27:24], slot_mode[31:28],
  // slot_number[38:32], slot_modifier_code[42:39], slot_key[50:43], zeros.
  input  logic [55:0] in_tdata,
  // in_tuser: req_type.
  input  logic        in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata, from bit 0: matched_slot[3:0], key_code[11:4],
  // modifier_mask[15:12], pass_status[23:16], pass_first[31:24],
  // pass_second[39:32].
  output logic [39:0] out_tdata,
  // out_tuser: action.
  output logic [1:0]  out_tuser,
  output logic        out_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import mevk_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  // One result as held in the pending and output registers.
  typedef struct packed {
    logic [1:0] action;
    logic [3:0] slot;
    logic [7:0] key;
    logic [3:0] mask;
    logic [7:0] p_status;
    logic [7:0] p_first;
    logic [7:0] p_second;
    logic       last;
  } result_t;

  state_t      state_r, state_nxt;
  logic [SLOT_W-1:0] cnt_r, cnt_nxt;
  logic [4:0]  listen_r, listen_nxt;
  logic [6:0]  last_prog_r [16];
  msg_t        msg_r, msg_nxt;
  logic [7:0]  raw_status_r, raw_first_r, raw_second_r;
  logic        pend_valid_r, pend_valid_nxt;
  result_t     pend_r, pend_nxt;
  logic        out_valid_r, out_valid_nxt;
  result_t     out_r, out_nxt;

  // Input fields.
  logic [7:0]  in_status, in_first, in_second;
  logic [3:0]  in_idx, in_mode, in_mod;
  logic [6:0]  in_number;
  logic [7:0]  in_key;
  logic [3:0]  in_chan;
  logic        in_xfer, msg_go, wr_go, cfg_wr;
  logic        out_free, step;
  slot_t       wr_slot;
  cell_t       cell_q [NUM_SLOTS];
  cell_t       head_upd;
  match_t      mres;
  result_t     hit_res, pass_res;

  assign in_status = in_tdata[7:0];
  assign in_first  = in_tdata[15:8];
  assign in_second = in_tdata[23:16];
  assign in_idx    = in_tdata[27:24];
  assign in_mode   = in_tdata[31:28];
  assign in_number = in_tdata[38:32];
  assign in_mod    = in_tdata[42:39];
  assign in_key    = in_tdata[50:43];
  assign in_chan   = in_status[3:0];

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign msg_go    = in_xfer && !in_tuser;
  assign wr_go     = in_xfer && in_tuser;
  assign out_free  = !out_valid_r || out_tready;
  assign step      = (state_r == ST_SCAN) && out_free;

  // Mode codes above slider down are stored as slider down.
  assign wr_slot.mode     = (in_mode > MODE_SL_DN) ? MODE_SL_DN : in_mode;
  assign wr_slot.number   = in_number;
  assign wr_slot.mod_code = in_mod;
  assign wr_slot.key      = in_key;

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {27'd0, listen_r} : 32'd0;
  assign listen_nxt = (cfg_wr && (cfg_paddr[2] == 1'b0)) ? cfg_pwdata[4:0] : listen_r;

  // The ring of slot cells: cell 0 is the head seen by the match unit, and
  // the head comes back at the tail with its held mark updated.
  assign head_upd.held = mres.held_nxt;
  assign head_upd.slot = cell_q[0].slot;

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    cell_t sin;
    logic  wsel;
    if (i == NUM_SLOTS - 1) begin : g_tail
      assign sin = head_upd;
    end else begin : g_mid
      assign sin = cell_q[i+1];
    end
    assign wsel = wr_go && ({4'd0, in_idx} == 8'(i));
    mevk_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .wr_en    (wsel),
      .wr_slot  (wr_slot),
      .shift_en (step),
      .shift_in (sin),
      .q        (cell_q[i])
    );
  end

  mevk_match u_match (
    .head (cell_q[0]),
    .msg  (msg_r),
    .res  (mres)
  );

  // A message is decoded once at its transfer; note on with velocity zero
  // becomes note off.
  always_comb begin
    msg_nxt = msg_r;
    if (msg_go) begin
      msg_nxt.d1        = in_first[6:0];
      msg_nxt.d2        = in_second[6:0];
      msg_nxt.last_prog = last_prog_r[in_chan];
      msg_nxt.listen_ok = (listen_r == 5'd0) || (listen_r == {1'b0, in_chan} + 5'd1);
      if ((in_status[7:4] == TYPE_NOTE_ON) && (in_second[6:0] == 7'd0)) begin
        msg_nxt.msg_type = TYPE_NOTE_OFF;
      end else begin
        msg_nxt.msg_type = in_status[7:4];
      end
    end
  end

  always_comb begin
    hit_res.action   = mres.action;
    hit_res.slot     = 4'(cnt_r);
    hit_res.key      = cell_q[0].slot.key;
    hit_res.mask     = mod_decode(cell_q[0].slot.mod_code);
    hit_res.p_status = 8'd0;
    hit_res.p_first  = 8'd0;
    hit_res.p_second = 8'd0;
    hit_res.last     = 1'b0;

    pass_res.action   = ACT_PASS;
    pass_res.slot     = 4'd0;
    pass_res.key      = 8'd0;
    pass_res.mask     = 4'd0;
    pass_res.p_status = raw_status_r;
    pass_res.p_first  = raw_first_r;
    pass_res.p_second = raw_second_r;
    pass_res.last     = 1'b1;
  end

  // Sequencer. A hit is parked in the pending register until the next hit
  // or the end of the scan tells whether it is the final result.
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_nxt        = out_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (msg_go) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (step) begin
          if (mres.fire) begin
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_nxt       = pend_r;
            end
            pend_valid_nxt = 1'b1;
            pend_nxt       = hit_res;
          end
          if (cnt_r == SLOT_W'(NUM_SLOTS - 1)) begin
            cnt_nxt   = '0;
            state_nxt = ST_DONE;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          pend_valid_nxt = 1'b0;
          if (pend_valid_r) begin
            out_nxt      = pend_r;
            out_nxt.last = 1'b1;
          end else begin
            out_nxt = pass_res;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      listen_r     <= 5'd0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int k = 0; k < 16; k++) begin
        last_prog_r[k] <= 7'd0;
      end
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      listen_r     <= listen_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      // The scan uses the copy latched into msg_r, so the channel's last
      // program can be updated right at the transfer.
      if (msg_go && (in_status[7:4] == TYPE_PROG)) begin
        last_prog_r[in_chan] <= in_first[6:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    msg_r  <= msg_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
    if (msg_go) begin
      raw_status_r <= in_status;
      raw_first_r  <= in_first;
      raw_second_r <= in_second;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.action;
  assign out_tlast  = out_r.last;
  assign out_tdata  = {out_r.p_second, out_r.p_first, out_r.p_status,
                       out_r.mask, out_r.key, out_r.slot};

`ifndef ASSERT_OFF
  a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> (state_r != ST_IDLE))
    else $error("pending result outside of a scan");

  a_msg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    msg_go |=> !in_tready)
    else $error("input accepted during a scan");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DONE) && out_free) |=> (out_tvalid && out_tlast))
    else $error("scan ended without a final result");

  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (cnt_r == '0))
    else $error("slot counter not cleared while idle");
`endif

endmodule
